@@ hw/rtl/irpw_pkg.sv @@
// Shared types and constants for the pulse-width IR byte encoder.
// No dependencies.
package irpw_pkg;

   localparam int unsigned TICK_W = 8;
   localparam int unsigned SYM_W = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [SYM_W-1:0] FRAME_SYMBOLS = 4'd9;

   localparam logic [TICK_W-1:0] RST_START_TICKS = 8'd96;
   localparam logic [TICK_W-1:0] RST_ONE_TICKS = 8'd64;
   localparam logic [TICK_W-1:0] RST_ZERO_TICKS = 8'd32;
   localparam logic [TICK_W-1:0] RST_GAP_TICKS = 8'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TICKS = 2'd0,
      CSR_ONE_TICKS = 2'd1,
      CSR_ZERO_TICKS = 2'd2,
      CSR_GAP_TICKS = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SEND = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0] data_byte;
   } op_type;

   typedef struct packed {
      logic carrier_on;
      logic busy;
      logic accepted;
   } result_type;

endpackage

@@ hw/rtl/ir_pulse_width_byte_encoder_unit.sv @@
// A request's response passes through the front register, the queue and then the response register.
// Throughput: one request per cycle while rsp_ready holds; the back stage does one tick or send per cycle.
// The front register, a 2-entry queue and the response register let each side stall alone.
// Reset is synchronous, active high: frame idle, carrier off, queue empty,
// timing registers back to 96/64/32/32.
// Top level of the pulse-width IR byte encoder; depends on irpw_pkg and submodules.
module ir_pulse_width_byte_encoder_unit import irpw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_carrier_on,
   output logic                 rsp_busy_res,
   output logic                 rsp_accepted
);

   logic       front_valid, front_ready;
   op_type     front_op;
   logic       back_valid, back_ready;
   op_type     back_op;
   result_type rsp;

   irpw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .op_valid      (front_valid),
      .op_ready      (front_ready),
      .op            (front_op)
   );

   irpw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_op    (front_op),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_op     (back_op)
   );

   irpw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_valid  (back_valid),
      .op_ready  (back_ready),
      .op        (back_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_carrier_on = rsp.carrier_on;
   assign rsp_busy_res = rsp.busy;
   assign rsp_accepted = rsp.accepted;

endmodule

@@ hw/rtl/irpw_front.sv @@
// Front stage: takes requests and classifies them into tick or send ops.
// Depends on irpw_pkg.
module irpw_front import irpw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       op_valid,
   input  logic       op_ready,
   output op_type     op
);

   logic   stage_valid_ff, stage_valid_in;
   op_type stage_op_ff, stage_op_in;
   logic   take;

   assign req_ready = !stage_valid_ff || op_ready;
   assign take = req_valid && req_ready;

   always_comb begin
      stage_valid_in = take || (stage_valid_ff && !op_ready);
      stage_op_in = stage_op_ff;
      if (take) begin
         stage_op_in.kind = req_cmd ? OP_SEND : OP_TICK;
         stage_op_in.data_byte = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_op_ff <= stage_op_in;
   end

   assign op_valid = stage_valid_ff;
   assign op = stage_op_ff;

endmodule

@@ hw/rtl/irpw_queue.sv @@
// Two-entry op queue between front and back.
// Depends on irpw_pkg.
module irpw_queue import irpw_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ hw/rtl/irpw_back.sv @@
// Back stage: frame sequencer, timing registers and result register.
// Depends on irpw_pkg.
module irpw_back import irpw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 op_valid,
   output logic                 op_ready,
   input  op_type               op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output result_type           rsp
);

   logic [TICK_W-1:0] start_ticks_ff, one_ticks_ff, zero_ticks_ff, gap_ticks_ff;
   logic [TICK_W-1:0] mark_count_ff, mark_count_in;
   logic [TICK_W-1:0] gap_count_ff, gap_count_in;
   logic [SYM_W-1:0]  symbols_left_ff, symbols_left_in;
   logic [7:0]        shift_bits_ff, shift_bits_in;
   logic              carrier_ff, carrier_in;
   logic              active_ff, active_in;
   logic              took;
   logic              step;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   assign op_ready = !rsp_valid_ff || rsp_ready;
   assign step = op_valid && op_ready;

   always_comb begin
      mark_count_in = mark_count_ff;
      gap_count_in = gap_count_ff;
      symbols_left_in = symbols_left_ff;
      shift_bits_in = shift_bits_ff;
      carrier_in = carrier_ff;
      active_in = active_ff;
      took = 1'b0;
      if (op.kind == OP_SEND) begin
         if (!active_ff) begin
            shift_bits_in = op.data_byte;
            symbols_left_in = FRAME_SYMBOLS;
            mark_count_in = '0;
            gap_count_in = '0;
            carrier_in = 1'b1;
            active_in = 1'b1;
            took = 1'b1;
         end
      end else if (active_ff) begin
         if (mark_count_ff != '0) begin
            mark_count_in = mark_count_ff - 8'd1;
            if (mark_count_ff == 8'd1) begin
               carrier_in = 1'b0;
            end
         end else if (gap_count_ff != '0) begin
            gap_count_in = gap_count_ff - 8'd1;
            if (gap_count_ff == 8'd1) begin
               carrier_in = 1'b1;
            end
         end else if (symbols_left_ff == FRAME_SYMBOLS) begin
            mark_count_in = start_ticks_ff;
            gap_count_in = gap_ticks_ff;
            symbols_left_in = symbols_left_ff - 4'd1;
         end else if (symbols_left_ff != '0) begin
            mark_count_in = shift_bits_ff[0] ? one_ticks_ff : zero_ticks_ff;
            gap_count_in = gap_ticks_ff;
            shift_bits_in = {1'b0, shift_bits_ff[7:1]};
            symbols_left_in = symbols_left_ff - 4'd1;
         end else begin
            carrier_in = 1'b0;
            active_in = 1'b0;
         end
      end
      rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
      rsp_in = rsp_ff;
      if (step) begin
         rsp_in.carrier_on = carrier_in;
         rsp_in.busy = active_in;
         rsp_in.accepted = took;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ticks_ff <= RST_START_TICKS;
         one_ticks_ff <= RST_ONE_TICKS;
         zero_ticks_ff <= RST_ZERO_TICKS;
         gap_ticks_ff <= RST_GAP_TICKS;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_TICKS: start_ticks_ff <= csr_wdata;
            CSR_ONE_TICKS:   one_ticks_ff <= csr_wdata;
            CSR_ZERO_TICKS:  zero_ticks_ff <= csr_wdata;
            CSR_GAP_TICKS:   gap_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_count_ff <= '0;
         gap_count_ff <= '0;
         symbols_left_ff <= '0;
         shift_bits_ff <= '0;
         carrier_ff <= 1'b0;
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            mark_count_ff <= mark_count_in;
            gap_count_ff <= gap_count_in;
            symbols_left_ff <= symbols_left_in;
            shift_bits_ff <= shift_bits_in;
            carrier_ff <= carrier_in;
            active_ff <= active_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

@@ hw/rtl/irpw_checker.sv @@
// Port-level checks for the pulse-width IR byte encoder, bound to the top level.
// Depends on irpw_pkg.
module irpw_checker import irpw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_carrier_on,
   input logic                 rsp_busy_res,
   input logic                 rsp_accepted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_carrier_on)
         && $stable(rsp_busy_res) && $stable(rsp_accepted))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_busy_res && rsp_carrier_on)
      else $error("accepted send without busy carrier");

   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_carrier_on)
      else $error("carrier on while idle");

endmodule

bind ir_pulse_width_byte_encoder_unit irpw_checker u_irpw_checker (.*);

@@ tb/irpw_frame_checker.sv @@
// Scoreboard for the pulse-width IR byte encoder: tracks timing register writes,
// predicts carrier/busy/accepted per request and compares each response in order.
// Depends on irpw_pkg.
`timescale 1ns / 100ps

module irpw_frame_checker import irpw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [7:0]           req_data_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_carrier_on,
   input  logic                 rsp_busy_res,
   input  logic                 rsp_accepted,
   output int                   errors,
   output int                   pending,
   output int                   frames_started,
   output int                   frames_ended,
   output int                   sends_refused
);

   logic [TICK_W-1:0] start_len, one_len, zero_len, gap_len;
   logic [TICK_W-1:0] mark_left, gap_left;
   logic [SYM_W-1:0]  symbols_left;
   logic [7:0]        bits_left;
   logic              carrier, active;
   int                rsp_count;
   result_type        emitter_states[$];

   task automatic report_mismatch(input string what);
      if (errors < 100)
         $display("%0t ns response %0d: %s", $time, rsp_count, what);
      errors++;
   endtask

   function automatic result_type advance_frame(input op_kind_type kind,
                                                input logic [7:0] byte_val);
      result_type r;
      r.accepted = 1'b0;
      if (kind == OP_SEND) begin
         if (!active) begin
            bits_left = byte_val;
            symbols_left = FRAME_SYMBOLS;
            mark_left = '0;
            gap_left = '0;
            carrier = 1'b1;
            active = 1'b1;
            r.accepted = 1'b1;
            frames_started++;
         end else begin
            sends_refused++;
         end
      end else if (active) begin
         if (mark_left != 0) begin
            mark_left = mark_left - 1'b1;
            if (mark_left == 0)
               carrier = 1'b0;
         end else if (gap_left != 0) begin
            gap_left = gap_left - 1'b1;
            if (gap_left == 0)
               carrier = 1'b1;
         end else if (symbols_left == FRAME_SYMBOLS) begin
            mark_left = start_len;
            gap_left = gap_len;
            symbols_left = symbols_left - 1'b1;
         end else if (symbols_left != 0) begin
            mark_left = bits_left[0] ? one_len : zero_len;
            gap_left = gap_len;
            bits_left = bits_left >> 1;
            symbols_left = symbols_left - 1'b1;
         end else begin
            carrier = 1'b0;
            active = 1'b0;
            frames_ended++;
         end
      end
      r.carrier_on = carrier;
      r.busy = active;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         start_len = RST_START_TICKS;
         one_len = RST_ONE_TICKS;
         zero_len = RST_ZERO_TICKS;
         gap_len = RST_GAP_TICKS;
         mark_left = '0;
         gap_left = '0;
         symbols_left = '0;
         bits_left = '0;
         carrier = 1'b0;
         active = 1'b0;
         emitter_states.delete();
         errors = 0;
         pending = 0;
         frames_started = 0;
         frames_ended = 0;
         sends_refused = 0;
         rsp_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_START_TICKS: start_len = csr_wdata;
               CSR_ONE_TICKS:   one_len = csr_wdata;
               CSR_ZERO_TICKS:  zero_len = csr_wdata;
               CSR_GAP_TICKS:   gap_len = csr_wdata;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (emitter_states.size() == 0) begin
               report_mismatch($sformatf("unexpected response carrier=%b busy=%b accepted=%b",
                                         rsp_carrier_on, rsp_busy_res, rsp_accepted));
            end else begin
               want = emitter_states.pop_front();
               if (rsp_carrier_on !== want.carrier_on)
                  report_mismatch($sformatf("carrier_on got %b want %b",
                                            rsp_carrier_on, want.carrier_on));
               if (rsp_busy_res !== want.busy)
                  report_mismatch($sformatf("busy_res got %b want %b",
                                            rsp_busy_res, want.busy));
               if (rsp_accepted !== want.accepted)
                  report_mismatch($sformatf("accepted got %b want %b",
                                            rsp_accepted, want.accepted));
            end
            rsp_count++;
         end
         if (req_valid && req_ready)
            emitter_states.push_back(advance_frame(op_kind_type'(req_cmd), req_data_byte));
         pending = emitter_states.size();
      end
   end

endmodule

@@ tb/ir_pulse_width_byte_encoder_unit_tb.sv @@
// Top of the pulse-width IR byte encoder testbench: clock, reset, timing register
// writes, request and response flow control, watchdog and verdict.
// Depends on irpw_pkg, ir_pulse_width_byte_encoder_unit and irpw_frame_checker.
`timescale 1ns / 100ps

module ir_pulse_width_byte_encoder_unit_tb;
   import irpw_pkg::*;

   localparam int LATENCY = 2;
   localparam int HOLD_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_START_TICKS;
   logic [TICK_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = OP_TICK;
   logic [7:0]           req_data_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_carrier_on;
   logic                 rsp_busy_res;
   logic                 rsp_accepted;

   int errors, pending, frames_started, frames_ended, sends_refused;
   int items_sent = 0;
   int stall_cycles = 0;
   bit no_gaps = 1'b0;
   bit hold_request = 1'b0;

   ir_pulse_width_byte_encoder_unit uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_carrier_on (rsp_carrier_on),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_accepted   (rsp_accepted)
   );

   irpw_frame_checker frame_chk (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_carrier_on (rsp_carrier_on),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_accepted   (rsp_accepted),
      .errors         (errors),
      .pending        (pending),
      .frames_started (frames_started),
      .frames_ended   (frames_ended),
      .sends_refused  (sends_refused)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, pending);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : receiver
      int span;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            span = HOLD_CYCLES;
         end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            span = $urandom_range(1, 3);
         end else begin
            rsp_ready <= 1'b1;
            span = $urandom_range(1, 8);
         end
         repeat (span) @(posedge clock);
      end
   end

   task automatic put_request(input op_kind_type kind, input logic [7:0] byte_val);
      int gap;
      if (!no_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= kind;
      req_data_byte <= byte_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [TICK_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_timing(input logic [TICK_W-1:0] start_v, input logic [TICK_W-1:0] one_v,
                               input logic [TICK_W-1:0] zero_v, input logic [TICK_W-1:0] gap_v);
      write_csr(CSR_START_TICKS, start_v);
      write_csr(CSR_ONE_TICKS, one_v);
      write_csr(CSR_ZERO_TICKS, zero_v);
      write_csr(CSR_GAP_TICKS, gap_v);
      csr_we <= 1'b0;
   endtask

   // send_odds: one send in that many requests; hold_at: request index that starts
   // the long response stall, or -1
   task automatic random_stream(input int count, input int send_odds, input int hold_at);
      op_kind_type kind;
      logic [7:0]  byte_val;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at)
            hold_request = 1'b1;
         kind = ($urandom_range(0, send_odds - 1) == 0) ? OP_SEND : OP_TICK;
         case ($urandom_range(0, 7))
            0:       byte_val = 8'h00;
            1:       byte_val = 8'hFF;
            default: byte_val = 8'($urandom());
         endcase
         put_request(kind, byte_val);
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle ticks, frame start with reset timing, send refused while busy
      put_request(OP_TICK, 8'h00);
      put_request(OP_TICK, 8'hFF);
      put_request(OP_SEND, 8'hFF);
      put_request(OP_SEND, 8'h00);
      repeat (4) put_request(OP_TICK, 8'h5A);
      put_request(OP_SEND, 8'hA5);
      put_request(OP_TICK, 8'h00);
      drain_pipeline();

      write_timing(8'd1, 8'd1, 8'd1, 8'd1);
      random_stream(180, 8, 100);
      drain_pipeline();

      write_timing(8'd255, 8'd255, 8'd255, 8'd255);
      random_stream(250, 40, -1);
      drain_pipeline();

      write_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                   8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
      random_stream(200, 10, -1);
      drain_pipeline();

      write_timing(8'd6, 8'd4, 8'd2, 8'd2);
      no_gaps = 1'b1;
      random_stream(110, 10, -1);
      drain_pipeline();

      $display("%0d requests: %0d frames started, %0d completed, %0d sends refused while busy",
               items_sent, frames_started, frames_ended, sends_refused);
      $display("timing sets: reset values, all minimum, all maximum, two short mixes");
      if (errors == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/irpw_pkg.sv
hw/rtl/irpw_front.sv
hw/rtl/irpw_queue.sv
hw/rtl/irpw_back.sv
hw/rtl/ir_pulse_width_byte_encoder_unit.sv
hw/rtl/irpw_checker.sv
tb/irpw_frame_checker.sv
tb/ir_pulse_width_byte_encoder_unit_tb.sv
